### hdl/pfa_pkg.sv
// Shared definitions for the partition fit allocator.
// Holds table sizes, request and policy codes, and the controller/datapath structs.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package pfa_pkg;

    // Table geometry and field widths.
    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int BIU_W      = 5;
    localparam int POLICY_W   = 2;
    localparam int TYPE_W     = 2;
    localparam int SLOT_W     = 4;
    localparam int AMOUNT_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'd1;

    // Reset value of the number of partitions searched.
    localparam logic [BIU_W-1:0] BLOCKS_RESET = BIU_W'(MAX_BLOCKS);

    // Item kinds; the fourth code is unused and produces an empty result.
    typedef enum logic [TYPE_W-1:0] {
        REQ_LOAD    = 2'd0,
        REQ_ALLOC   = 2'd1,
        REQ_RESTORE = 2'd2
    } t_req_type;

    // Placement policies.
    typedef enum logic [POLICY_W-1:0] {
        POL_FIRST = 2'd0,
        POL_NEXT  = 2'd1,
        POL_BEST  = 2'd2,
        POL_WORST = 2'd3
    } t_policy;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // register the accepted item
        logic start;      // set up a scan or restore sweep
        logic step;       // advance the sweep by one entry
        logic load_wr;    // write a loaded partition size
        logic update_wr;  // shrink the granted partition
        logic out_load;   // place the result in the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic              scan_done;
        logic              found;
        logic              out_free;
    } t_dp_sts;

endpackage

### hdl/pfa_ctrl.sv
// Controller state machine of the partition fit allocator.
// Sequences item capture, table sweeps, the size update and the result transfer.
// Depends on pfa_pkg for the command and status structs and request codes.
`timescale 1ns / 1ps

module pfa_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [pfa_pkg::TYPE_W-1:0]    i_req_type,
    output logic                          o_in_ready,
    input  pfa_pkg::t_dp_sts              i_sts,
    output pfa_pkg::t_dp_cmd              o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOAD   = 6'b000010,
        ST_START  = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_FINISH = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    if (i_req_type == pfa_pkg::REQ_LOAD) begin
                        n_state = ST_LOAD;
                    end else if (i_req_type == pfa_pkg::REQ_ALLOC ||
                                 i_req_type == pfa_pkg::REQ_RESTORE) begin
                        n_state = ST_START;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.load_wr = 1'b1;
                n_state       = ST_FINISH;
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state     = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    if (i_sts.req_type == pfa_pkg::REQ_ALLOC && i_sts.found) begin
                        n_state = ST_UPDATE;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_UPDATE: begin
                o_cmd.update_wr = 1'b1;
                n_state         = ST_FINISH;
            end
            ST_FINISH: begin
                // Wait here only while an earlier result is still unclaimed.
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/pfa_datapath.sv
// Datapath of the partition fit allocator: size tables, sweep counters,
// fit comparison, next-fit pointer and the output register.
// Depends on pfa_pkg; driven by pfa_ctrl through command and status structs.
`timescale 1ns / 1ps

module pfa_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pfa_pkg::t_dp_cmd                i_cmd,
    output pfa_pkg::t_dp_sts                o_sts,
    input  logic [pfa_pkg::TYPE_W-1:0]      i_req_type,
    input  logic [pfa_pkg::SLOT_W-1:0]      i_slot,
    input  logic [pfa_pkg::AMOUNT_W-1:0]    i_amount,
    input  logic [pfa_pkg::POLICY_W-1:0]    i_fit_policy,
    input  logic [pfa_pkg::CNT_W-1:0]       i_active,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_granted,
    output logic [pfa_pkg::SLOT_W-1:0]      o_chosen_slot,
    output logic [pfa_pkg::AMOUNT_W-1:0]    o_space_left
);

    localparam int IW = pfa_pkg::IDX_W;
    localparam int CW = pfa_pkg::CNT_W;
    localparam int SW = pfa_pkg::SIZE_BITS;

    // Size tables, one write and one registered read port each.
    logic [SW-1:0] r_orig_mem [pfa_pkg::MAX_BLOCKS];
    logic [SW-1:0] r_rem_mem  [pfa_pkg::MAX_BLOCKS];
    logic [SW-1:0] r_orig_q;
    logic [SW-1:0] r_rem_q;

    // Captured item.
    logic [pfa_pkg::TYPE_W-1:0] r_type;
    logic [IW-1:0]              r_slot;
    logic [SW-1:0]              r_req;

    // Sweep state.
    logic [CW-1:0] r_limit;
    logic [CW-1:0] r_issued;
    logic [IW-1:0] r_pos;
    logic [IW-1:0] r_q_idx;
    logic          r_q_vld;

    // Search result and next-fit pointer.
    logic          r_found;
    logic [IW-1:0] r_pick;
    logic [SW-1:0] r_pick_size;
    logic [IW-1:0] r_next_ptr;

    // Output register.
    logic                         r_out_valid;
    logic                         r_res_granted;
    logic [pfa_pkg::SLOT_W-1:0]   r_res_slot;
    logic [pfa_pkg::AMOUNT_W-1:0] r_res_space;

    logic          is_alloc;
    logic          is_restore;
    logic [IW-1:0] pos_next;
    logic [SW-1:0] new_size;
    logic          fits;
    logic          take;
    logic          orig_we;
    logic          rem_we;
    logic [IW-1:0] rem_addr;
    logic [SW-1:0] rem_data;
    logic          granted_now;

    assign is_alloc   = (r_type == pfa_pkg::REQ_ALLOC);
    assign is_restore = (r_type == pfa_pkg::REQ_RESTORE);
    assign pos_next   = ((CW'(r_pos) + CW'(1)) == r_limit) ? '0 : r_pos + IW'(1);
    assign new_size   = r_pick_size - r_req;

    // Fit decision for the entry whose size has just been read.
    assign fits = (r_rem_q >= r_req);
    always_comb begin
        unique case (pfa_pkg::t_policy'(i_fit_policy))
            pfa_pkg::POL_FIRST,
            pfa_pkg::POL_NEXT:  take = fits && !r_found;
            pfa_pkg::POL_BEST:  take = fits && (!r_found || r_rem_q < r_pick_size);
            pfa_pkg::POL_WORST: take = fits && (!r_found || r_rem_q > r_pick_size);
            default:            take = 1'b0;
        endcase
    end

    // Table write selection: load, granted update, or restore copy.
    assign orig_we = i_cmd.load_wr;
    assign rem_we  = i_cmd.load_wr || i_cmd.update_wr ||
                     (i_cmd.step && r_q_vld && is_restore);
    always_comb begin
        priority if (i_cmd.load_wr) begin
            rem_addr = r_slot;
            rem_data = r_req;
        end else if (i_cmd.update_wr) begin
            rem_addr = r_pick;
            rem_data = new_size;
        end else begin
            rem_addr = r_q_idx;
            rem_data = r_orig_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (orig_we) begin
            r_orig_mem[r_slot] <= r_req;
        end
        r_orig_q <= r_orig_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (rem_we) begin
            r_rem_mem[rem_addr] <= rem_data;
        end
        r_rem_q <= r_rem_mem[r_pos];
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type <= i_req_type;
            r_slot <= IW'(i_slot);
            r_req  <= SW'(i_amount);
        end
    end

    // Sweep counters and search bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld    <= 1'b0;
            r_found    <= 1'b0;
            r_next_ptr <= '0;
            r_issued   <= '0;
            r_limit    <= '0;
        end else if (i_cmd.start) begin
            r_issued <= '0;
            r_q_vld  <= 1'b0;
            r_found  <= 1'b0;
            if (is_restore) begin
                r_limit    <= CW'(pfa_pkg::MAX_BLOCKS);
                r_pos      <= '0;
                r_next_ptr <= '0;
            end else begin
                r_limit <= i_active;
                if (i_fit_policy == pfa_pkg::POL_NEXT && CW'(r_next_ptr) < i_active) begin
                    r_pos <= r_next_ptr;
                end else begin
                    r_pos <= '0;
                end
            end
        end else if (i_cmd.step) begin
            if (r_issued != r_limit) begin
                r_q_vld  <= 1'b1;
                r_q_idx  <= r_pos;
                r_pos    <= pos_next;
                r_issued <= r_issued + CW'(1);
            end else begin
                r_q_vld <= 1'b0;
            end
            if (r_q_vld && is_alloc && take) begin
                r_found     <= 1'b1;
                r_pick      <= r_q_idx;
                r_pick_size <= r_rem_q;
            end
        end else if (i_cmd.update_wr && i_fit_policy == pfa_pkg::POL_NEXT) begin
            r_next_ptr <= r_pick;
        end
    end

    // Output register: a finished result waits here until transferred.
    assign granted_now = is_alloc && r_found;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_res_granted <= granted_now;
            r_res_slot    <= granted_now ? pfa_pkg::SLOT_W'(r_pick) : '0;
            r_res_space   <= granted_now ? pfa_pkg::AMOUNT_W'(new_size) : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_granted     = r_res_granted;
    assign o_chosen_slot = r_res_slot;
    assign o_space_left  = r_res_space;

    // Status back to the controller.
    assign o_sts.req_type  = r_type;
    assign o_sts.scan_done = (r_issued == r_limit) && !r_q_vld;
    assign o_sts.found     = r_found;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

endmodule

### hdl/partition_fit_allocator.sv
// Partition fit allocator: input and output channels use valid/ready; a transfer
// happens on a rising edge with both high. Each input item yields one result.
// A load item sets a partition's original and remaining size; a restore item
// copies every original size back and clears the next-fit pointer; an allocate
// item searches partitions 0 to blocks_in_use-1, at most 0 to 15, by fit_policy
// and shrinks the granted one. Configuration is written through
// i_cfg_we/i_cfg_index/i_cfg_wdata only while the block is idle; the user must
// keep to this, as the block itself does not enforce it. Each size table has a
// single read port, so a sweep reads and compares one partition per cycle. One
// item is in work at a time; a new item is taken once the previous result sits
// in the output register.
// If the receiver stalls, the result holds in the output register; the next
// item is still accepted and worked, then waits until the register frees.
// Synchronous reset clears the control state, sets fit_policy to first fit,
// blocks_in_use to 16 and the next-fit pointer to 0; the size tables are not
// cleared and must be loaded before use.
// Depends on pfa_pkg, pfa_ctrl and pfa_datapath.
`timescale 1ns / 1ps

module partition_fit_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [pfa_pkg::TYPE_W-1:0]        i_req_type,
    input  logic [pfa_pkg::SLOT_W-1:0]        i_slot,
    input  logic [pfa_pkg::AMOUNT_W-1:0]      i_amount,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_granted,
    output logic [pfa_pkg::SLOT_W-1:0]        o_chosen_slot,
    output logic [pfa_pkg::AMOUNT_W-1:0]      o_space_left,
    input  logic                              i_cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    logic [pfa_pkg::POLICY_W-1:0] r_fit_policy;
    logic [pfa_pkg::BIU_W-1:0]    r_blocks;
    logic [pfa_pkg::CNT_W-1:0]    active;
    pfa_pkg::t_dp_cmd             cmd;
    pfa_pkg::t_dp_sts             sts;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_policy <= pfa_pkg::POL_FIRST;
            r_blocks     <= pfa_pkg::BLOCKS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pfa_pkg::CFG_FIT_POLICY:    r_fit_policy <= i_cfg_wdata[pfa_pkg::POLICY_W-1:0];
                pfa_pkg::CFG_BLOCKS_IN_USE: r_blocks     <= i_cfg_wdata[pfa_pkg::BIU_W-1:0];
                default: ;
            endcase
        end
    end

    // Number of partitions searched, saturated at the table depth.
    assign active = (r_blocks > pfa_pkg::BIU_W'(pfa_pkg::MAX_BLOCKS)) ?
                    pfa_pkg::CNT_W'(pfa_pkg::MAX_BLOCKS) : pfa_pkg::CNT_W'(r_blocks);

    pfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pfa_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req_type),
        .i_slot        (i_slot),
        .i_amount      (i_amount),
        .i_fit_policy  (r_fit_policy),
        .i_active      (active),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_granted     (o_granted),
        .o_chosen_slot (o_chosen_slot),
        .o_space_left  (o_space_left)
    );

`ifndef NO_ASSERTIONS
    // One item at a time: an input transfer closes the input side next cycle.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted twice in a row");

    // A granted partition lies inside the searched range.
    a_grant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_granted) |-> (pfa_pkg::CNT_W'(o_chosen_slot) < active))
        else $error("granted partition outside the searched range");

    // A result without a grant carries zero slot and size.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_granted) |-> (o_chosen_slot == '0 && o_space_left == '0))
        else $error("non-granted result carries data");
`endif

endmodule

### tb/partition_fit_allocator_tb.sv
// Self-checking testbench for partition_fit_allocator: a scoreboard class predicts every
// grant from its own copy of the partition table, and plain tasks drive the block.
// Depends on pfa_pkg and the partition_fit_allocator RTL.
`timescale 1ns / 1ps

module partition_fit_allocator_tb;

    localparam int          CLK_HALF    = 10;
    localparam int          RUN_LIMIT   = 800000;
    localparam int          PHASES      = 20;
    localparam int          PHASE_ITEMS = 100;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [pfa_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;

    // One result as seen on the output channel.
    typedef struct packed {
        logic                         granted;
        logic [pfa_pkg::SLOT_W-1:0]   slot;
        logic [pfa_pkg::AMOUNT_W-1:0] space;
    } t_grant;

    // Scoreboard: keeps its own partition table and the grants still owed by the block.
    class grant_scoreboard;
        logic [pfa_pkg::SIZE_BITS-1:0] orig_size [pfa_pkg::MAX_BLOCKS];
        logic [pfa_pkg::SIZE_BITS-1:0] free_size [pfa_pkg::MAX_BLOCKS];
        logic [pfa_pkg::IDX_W-1:0]     rover;
        pfa_pkg::t_policy              policy;
        logic [pfa_pkg::BIU_W-1:0]     searched;
        t_grant                        owed_grants[$];
        int unsigned                   errors;
        int unsigned                   noted;
        int unsigned                   checked;
        int unsigned                   loads;
        int unsigned                   allocs;
        int unsigned                   grants;
        int unsigned                   restores;
        int unsigned                   unused;

        function new();
            foreach (orig_size[i]) begin
                orig_size[i] = '0;
                free_size[i] = '0;
            end
            rover       = '0;
            policy      = pfa_pkg::POL_FIRST;
            searched    = pfa_pkg::BLOCKS_RESET;
            errors      = 0;
            noted       = 0;
            checked     = 0;
            loads       = 0;
            allocs      = 0;
            grants      = 0;
            restores    = 0;
            unused      = 0;
        endfunction

        task report(string what);
            $display("%0t MISMATCH: %s", $realtime, what);
            errors++;
        endtask

        function void set_register(logic [pfa_pkg::CFG_IDX_W-1:0] idx,
                                   logic [pfa_pkg::CFG_DATA_W-1:0] value);
            if (idx == pfa_pkg::CFG_FIT_POLICY) begin
                policy = pfa_pkg::t_policy'(value[pfa_pkg::POLICY_W-1:0]);
            end else begin
                searched = value[pfa_pkg::BIU_W-1:0];
            end
        endfunction

        // Returns the partition chosen for a request, or -1 when none fits.
        function int place_request(logic [pfa_pkg::SIZE_BITS-1:0] amount);
            int n;
            int pick;
            int pos;
            n    = (searched > pfa_pkg::MAX_BLOCKS) ? pfa_pkg::MAX_BLOCKS : int'(searched);
            pick = -1;
            if (n == 0) begin
                return -1;
            end
            if (policy == pfa_pkg::POL_NEXT) begin
                pos = (int'(rover) < n) ? int'(rover) : 0;
                for (int k = 0; k < n; k++) begin
                    if (free_size[pos] >= amount) begin
                        return pos;
                    end
                    pos = (pos + 1 == n) ? 0 : pos + 1;
                end
                return -1;
            end
            for (int j = 0; j < n; j++) begin
                if (free_size[j] >= amount) begin
                    if (policy == pfa_pkg::POL_FIRST) begin
                        return j;
                    end
                    if (pick < 0 ||
                        (policy == pfa_pkg::POL_BEST && free_size[j] < free_size[pick]) ||
                        (policy == pfa_pkg::POL_WORST && free_size[j] > free_size[pick])) begin
                        pick = j;
                    end
                end
            end
            return pick;
        endfunction

        // Notes an accepted input transfer and queues the grant it must produce.
        function void note_item(logic [pfa_pkg::TYPE_W-1:0] kind,
                                logic [pfa_pkg::SLOT_W-1:0] slot,
                                logic [pfa_pkg::AMOUNT_W-1:0] amount);
            t_grant res;
            int     pick;
            res = '0;
            noted++;
            case (kind)
                pfa_pkg::REQ_LOAD: begin
                    orig_size[slot] = amount;
                    free_size[slot] = amount;
                    loads++;
                end
                pfa_pkg::REQ_RESTORE: begin
                    foreach (free_size[i]) begin
                        free_size[i] = orig_size[i];
                    end
                    rover = '0;
                    restores++;
                end
                pfa_pkg::REQ_ALLOC: begin
                    allocs++;
                    pick = place_request(amount);
                    if (pick >= 0) begin
                        free_size[pick] = free_size[pick] - amount;
                        if (policy == pfa_pkg::POL_NEXT) begin
                            rover = pfa_pkg::IDX_W'(pick);
                        end
                        res.granted = 1'b1;
                        res.slot    = pfa_pkg::SLOT_W'(pick);
                        res.space   = free_size[pick];
                        grants++;
                    end
                end
                default: begin
                    unused++;
                end
            endcase
            owed_grants.push_back(res);
        endfunction

        // Compares one output transfer with the oldest owed grant, field by field.
        task check_grant(t_grant got);
            t_grant exp;
            if (owed_grants.size() == 0) begin
                report($sformatf("result %0b/%0d/%0d with no item outstanding",
                                 got.granted, got.slot, got.space));
                return;
            end
            exp = owed_grants.pop_front();
            checked++;
            if (got.granted !== exp.granted) begin
                report($sformatf("result %0d granted %0b, expected %0b",
                                 checked, got.granted, exp.granted));
            end
            if (got.slot !== exp.slot) begin
                report($sformatf("result %0d chosen_slot %0d, expected %0d",
                                 checked, got.slot, exp.slot));
            end
            if (got.space !== exp.space) begin
                report($sformatf("result %0d space_left %0d, expected %0d",
                                 checked, got.space, exp.space));
            end
        endtask

        function int pending();
            return owed_grants.size();
        endfunction

        task close_out();
            if (owed_grants.size() != 0) begin
                report($sformatf("%0d results never arrived", owed_grants.size()));
            end
        endtask
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic [pfa_pkg::TYPE_W-1:0]     i_req_type;
    logic [pfa_pkg::SLOT_W-1:0]     i_slot;
    logic [pfa_pkg::AMOUNT_W-1:0]   i_amount;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic                           o_granted;
    logic [pfa_pkg::SLOT_W-1:0]     o_chosen_slot;
    logic [pfa_pkg::AMOUNT_W-1:0]   o_space_left;
    logic                           i_cfg_we;
    logic [pfa_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [pfa_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    grant_scoreboard sb = new();
    int unsigned     settings_applied;
    logic            reset_done;

    partition_fit_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_slot        (i_slot),
        .i_amount      (i_amount),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_granted     (o_granted),
        .o_chosen_slot (o_chosen_slot),
        .o_space_left  (o_space_left),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        repeat (RUN_LIMIT) @(posedge i_clk);
        $display("Run limit of %0d cycles reached with %0d results owed",
                 RUN_LIMIT, sb.pending());
        $display("[FAIL] regression broken");
        $finish;
    end

    // Every output transfer is checked against the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_grant({o_granted, o_chosen_slot, o_space_left});
        end
    end

    // Receiver: random stall pattern, with one long hold-off while the sender is offering.
    initial begin
        bit held_off;
        int mode;
        int span;
        held_off = 1'b0;
        i_out_ready <= 1'b0;
        wait (reset_done === 1'b1);
        forever begin
            if (!held_off && sb.noted >= 500 && i_in_valid === 1'b1) begin
                held_off = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 40);
            repeat (span) begin
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= ($urandom_range(0, 3) == 0);
                    2:       i_out_ready <= ($urandom_range(0, 1) == 1);
                    default: i_out_ready <= ($urandom_range(0, 4) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Offers one item and returns at the edge where it transfers.
    task automatic send_item(input logic [pfa_pkg::TYPE_W-1:0] kind,
                             input logic [pfa_pkg::SLOT_W-1:0] slot,
                             input logic [pfa_pkg::AMOUNT_W-1:0] amount);
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_slot     <= slot;
        i_amount   <= amount;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_item(kind, slot, amount);
    endtask

    // Waits until every owed result has come back and the block is quiet.
    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes both registers on consecutive edges; only called while the block is idle.
    task automatic apply_settings(input pfa_pkg::t_policy pol,
                                  input logic [pfa_pkg::BIU_W-1:0] count);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= pfa_pkg::CFG_FIT_POLICY;
        i_cfg_wdata <= pfa_pkg::CFG_DATA_W'(pol);
        @(posedge i_clk);
        sb.set_register(pfa_pkg::CFG_FIT_POLICY, pfa_pkg::CFG_DATA_W'(pol));
        i_cfg_index <= pfa_pkg::CFG_BLOCKS_IN_USE;
        i_cfg_wdata <= pfa_pkg::CFG_DATA_W'(count);
        @(posedge i_clk);
        sb.set_register(pfa_pkg::CFG_BLOCKS_IN_USE, pfa_pkg::CFG_DATA_W'(count));
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Sizes and requests lean towards small values so that grants and misses both occur.
    function automatic logic [pfa_pkg::AMOUNT_W-1:0] pick_amount(int unsigned spread);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return pfa_pkg::AMOUNT_W'($urandom);
            default: return pfa_pkg::AMOUNT_W'($urandom_range(0, spread));
        endcase
    endfunction

    // Sends a burst of random items, then leaves a gap unless the next burst follows at once.
    task automatic send_burst(input int count);
        int roll;
        int gap;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                send_item(pfa_pkg::REQ_ALLOC, pfa_pkg::SLOT_W'($urandom), pick_amount(600));
            end else if (roll < 82) begin
                send_item(pfa_pkg::REQ_LOAD, pfa_pkg::SLOT_W'($urandom), pick_amount(3000));
            end else if (roll < 94) begin
                send_item(pfa_pkg::REQ_RESTORE, pfa_pkg::SLOT_W'($urandom),
                          pfa_pkg::AMOUNT_W'($urandom));
            end else begin
                send_item(REQ_UNUSED, pfa_pkg::SLOT_W'($urandom), pfa_pkg::AMOUNT_W'($urandom));
            end
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Main sequence: reset, directed items, then random phases under changing settings.
    initial begin
        logic [pfa_pkg::AMOUNT_W-1:0] seed_sizes [pfa_pkg::MAX_BLOCKS];
        int                           sent;
        int                           burst;
        pfa_pkg::t_policy             pol;
        logic [pfa_pkg::BIU_W-1:0]    count;
        seed_sizes = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'hAAAA,
                       16'h5555, 16'd100, 16'd200, 16'd300, 16'd50, 16'hFFFE,
                       16'd7, 16'd1000, 16'd500, 16'h0001};
        settings_applied = 0;
        reset_done  = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_req_type  <= pfa_pkg::REQ_LOAD;
        i_slot      <= '0;
        i_amount    <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= pfa_pkg::CFG_FIT_POLICY;
        i_cfg_wdata <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        reset_done = 1'b1;

        // Every partition is loaded first, so no search ever touches an unwritten entry.
        for (int s = 0; s < pfa_pkg::MAX_BLOCKS; s++) begin
            send_item(pfa_pkg::REQ_LOAD, pfa_pkg::SLOT_W'(s), seed_sizes[s]);
        end
        // Zero request, full-size request that empties a partition, then one that fits nowhere.
        send_item(pfa_pkg::REQ_ALLOC, '0, '0);
        send_item(pfa_pkg::REQ_ALLOC, '1, '1);
        send_item(pfa_pkg::REQ_ALLOC, '1, '1);
        send_item(REQ_UNUSED, '1, '1);
        send_item(pfa_pkg::REQ_RESTORE, '0, '0);
        i_in_valid <= 1'b0;
        drain();

        // One request under each policy, including a search of no partitions and a
        // count above the table size.
        apply_settings(pfa_pkg::POL_NEXT, 5'd16);
        send_item(pfa_pkg::REQ_ALLOC, '0, 16'd100);
        i_in_valid <= 1'b0;
        drain();
        apply_settings(pfa_pkg::POL_BEST, 5'd16);
        send_item(pfa_pkg::REQ_ALLOC, '0, 16'd100);
        i_in_valid <= 1'b0;
        drain();
        apply_settings(pfa_pkg::POL_WORST, 5'd31);
        send_item(pfa_pkg::REQ_ALLOC, '0, 16'd1);
        i_in_valid <= 1'b0;
        drain();
        apply_settings(pfa_pkg::POL_FIRST, 5'd0);
        send_item(pfa_pkg::REQ_ALLOC, '0, 16'd0);
        i_in_valid <= 1'b0;
        drain();
        // The next-fit pointer now lies beyond the single partition searched.
        apply_settings(pfa_pkg::POL_NEXT, 5'd1);
        send_item(pfa_pkg::REQ_ALLOC, '0, 16'd0);
        i_in_valid <= 1'b0;
        drain();

        // Random phases, each under fresh settings.
        for (int p = 0; p < PHASES; p++) begin
            pol = pfa_pkg::t_policy'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       count = 5'd0;
                1:       count = pfa_pkg::BIU_W'($urandom_range(17, 31));
                2:       count = 5'd16;
                3:       count = 5'd1;
                default: count = pfa_pkg::BIU_W'($urandom_range(2, 16));
            endcase
            apply_settings(pol, count);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 12);
                send_burst(burst);
                sent += burst;
            end
            i_in_valid <= 1'b0;
            drain();
        end

        repeat (30) @(posedge i_clk);
        sb.close_out();
        $display("Covered %0d input transfers: %0d loads, %0d allocations (%0d granted),",
                 sb.noted, sb.loads, sb.allocs, sb.grants);
        $display("%0d restores and %0d unused codes over %0d settings; %0d mismatches.",
                 sb.restores, sb.unused, settings_applied, sb.errors);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
